// ===== rtl/assert_macros.svh =====
// Assertion macros used by the checker file of the tooth decoder.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is switched off while reset is asserted.
`define ASSERT_RST(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("assertion failed");

// Clocked assertion that is checked at every edge, in reset as well.
`define ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("assertion failed");

`endif

// ===== rtl/cdgt_pkg.sv =====
// Shared types and constants of the dual gap crank tooth decoder.
`timescale 1ns / 1ps
package cdgt_pkg;

  localparam int unsigned TIME_W = 32;
  localparam int unsigned CNT_W = 6;
  localparam int unsigned REV_W = 16;
  localparam int unsigned CFG_W = 16;
  localparam int unsigned LVL_W = 2;

  localparam int unsigned WRAP_TOOTH_DEF = 36;
  localparam logic [CNT_W-1:0] SINGLE_GAP_TOOTH = 6'd20;
  localparam logic [CNT_W-1:0] FIRST_TOOTH = 6'd1;
  localparam logic [TIME_W-1:0] FILTER_RESET = 32'd208;

  typedef enum logic {
    CFG_INITIAL_FILTER = 1'b0,
    CFG_FILTER_LEVEL   = 1'b1
  } cfg_idx_e;

  typedef enum logic [LVL_W-1:0] {
    FILT_OFF     = 2'd0,
    FILT_QUARTER = 2'd1,
    FILT_HALF    = 2'd2,
    FILT_3QUART  = 2'd3
  } filt_lvl_e;

  typedef struct packed {
    logic              accepted;
    logic [CNT_W-1:0]  tooth_number;
    logic              in_sync;
    logic              angle_regular;
    logic              revolution_phase;
    logic [REV_W-1:0]  revolutions;
    logic [TIME_W-1:0] gap_us;
    logic [TIME_W-1:0] first_tooth_time;
  } result_t;

endpackage

// ===== rtl/cdgt_core.sv =====
// Tooth decoder state and the combinational update for one tooth edge.
`timescale 1ns / 1ps
module cdgt_core import cdgt_pkg::*; #(
  parameter int unsigned WRAP_TOOTH = WRAP_TOOTH_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              fire_i,
  input  logic [TIME_W-1:0] tooth_time_i,
  input  logic              cfg_we_i,
  input  cfg_idx_e          cfg_index_i,
  input  logic [CFG_W-1:0]  cfg_wdata_i,
  output result_t           result_o
);

  localparam logic [CNT_W-1:0] WrapCnt = CNT_W'(WRAP_TOOTH);

  logic [TIME_W-1:0] last_q, last_d, before_q, before_d;
  logic [TIME_W-1:0] filter_q, filter_d, t1_q, t1_d;
  logic [TIME_W+1:0] thr3_q, thr3_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic [REV_W-1:0]  rev_q, rev_d;
  logic              sync_q, sync_d, reg_q, reg_d, phase_q, phase_d;
  filt_lvl_e         lvl_q, lvl_d;

  logic [TIME_W-1:0] raw_gap, gap;
  logic [TIME_W+1:0] gap_w, gap3;
  logic [CNT_W-1:0]  cnt_inc;
  logic              ok, hist_ok, is_gap, is_single, wrap;

  always_comb begin
    raw_gap   = tooth_time_i - last_q;
    ok        = raw_gap >= filter_q;
    hist_ok   = (last_q != '0) && (before_q != '0);
    gap       = hist_ok ? raw_gap : '0;
    gap_w     = {2'b00, gap};
    gap3      = gap_w + {1'b0, gap, 1'b0};
    // Thresholds are three times the previous gap and half of that.
    is_gap    = gap_w > (thr3_q >> 1);
    is_single = gap_w < thr3_q;
    cnt_inc   = cnt_q + FIRST_TOOTH;
    wrap      = (cnt_inc > WrapCnt) || (cnt_inc == FIRST_TOOTH);

    last_d   = last_q;
    before_d = before_q;
    filter_d = filter_q;
    thr3_d   = thr3_q;
    cnt_d    = cnt_q;
    rev_d    = rev_q;
    sync_d   = sync_q;
    reg_d    = reg_q;
    phase_d  = phase_q;
    t1_d     = t1_q;
    lvl_d    = lvl_q;

    if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_INITIAL_FILTER: filter_d = {{(TIME_W-CFG_W){1'b0}}, cfg_wdata_i};
        CFG_FILTER_LEVEL:   lvl_d = filt_lvl_e'(cfg_wdata_i[LVL_W-1:0]);
        default: ;
      endcase
    end else if (fire_i && ok) begin
      last_d   = tooth_time_i;
      before_d = last_q;
      thr3_d   = {2'b00, raw_gap} + {1'b0, raw_gap, 1'b0};
      if (is_gap) begin
        cnt_d    = is_single ? SINGLE_GAP_TOOTH : FIRST_TOOTH;
        sync_d   = 1'b1;
        reg_d    = 1'b0;
        filter_d = '0;
      end else begin
        cnt_d = cnt_inc;
        if (wrap) begin
          cnt_d   = FIRST_TOOTH;
          phase_d = ~phase_q;
          t1_d    = tooth_time_i;
          rev_d   = rev_q + 1'b1;
        end
        reg_d = 1'b1;
        case (lvl_q)
          FILT_QUARTER: filter_d = gap_w[TIME_W+1:2];
          FILT_HALF:    filter_d = gap_w[TIME_W:1];
          FILT_3QUART:  filter_d = gap3[TIME_W+1:2];
          default:      filter_d = '0;
        endcase
      end
    end

    result_o.accepted         = ok;
    result_o.tooth_number     = cnt_d;
    result_o.in_sync          = sync_d;
    result_o.angle_regular    = reg_d;
    result_o.revolution_phase = phase_d;
    result_o.revolutions      = rev_d;
    result_o.gap_us           = ok ? gap : raw_gap;
    result_o.first_tooth_time = t1_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_q   <= '0;
      before_q <= '0;
      filter_q <= FILTER_RESET;
      thr3_q   <= '0;
      cnt_q    <= '0;
      rev_q    <= '0;
      sync_q   <= 1'b0;
      reg_q    <= 1'b0;
      phase_q  <= 1'b0;
      t1_q     <= '0;
      lvl_q    <= FILT_OFF;
    end else begin
      last_q   <= last_d;
      before_q <= before_d;
      filter_q <= filter_d;
      thr3_q   <= thr3_d;
      cnt_q    <= cnt_d;
      rev_q    <= rev_d;
      sync_q   <= sync_d;
      reg_q    <= reg_d;
      phase_q  <= phase_d;
      t1_q     <= t1_d;
      lvl_q    <= lvl_d;
    end
  end

endmodule

// ===== rtl/cdgt_outreg.sv =====
// Result register of the tooth decoder with its downstream handshake.
`timescale 1ns / 1ps
module cdgt_outreg import cdgt_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    load_i,
  input  result_t result_i,
  output logic    ready_o,
  output logic    valid_o,
  input  logic    take_i,
  output result_t result_o
);

  logic    valid_q, valid_d;
  result_t data_q;

  assign ready_o = !valid_q || take_i;
  assign valid_d = load_i || (valid_q && !take_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      data_q <= result_i;
    end
  end

  assign valid_o  = valid_q;
  assign result_o = data_q;

endmodule

// ===== rtl/crank_dual_gap_tooth_decoder.sv =====
// Top level of the crank decoder for a wheel with one single and one double gap.
`timescale 1ns / 1ps
// Decoder for a 36-tooth crank wheel with a single missing tooth and a double
// missing tooth. Each input request carries the microsecond timestamp of one
// tooth edge; each edge yields exactly one result request that reports whether
// the edge passed the noise filter, the tooth number, sync and regular-angle
// flags, the revolution phase and count, the measured gap and the time of the
// latest wrap to tooth one. The block takes one edge per clock cycle while the
// output side is ready; each edge passes the input register and then the
// result register. The decoder state is updated from the input register, so
// consecutive edges need no spacing. The result register frees itself in the
// same cycle in which its request is taken, so the input keeps flowing while
// the output side is ready. The filter threshold starts at 208 us; a write of
// the initial filter register reloads it. The user must write configuration
// only while no edge is in flight; the block itself does not enforce it.
module crank_dual_gap_tooth_decoder import cdgt_pkg::*; #(
  parameter int unsigned WRAP_TOOTH = WRAP_TOOTH_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  input  logic [31:0]       s_axis_tdata,   // [31:0] tooth_time
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  // [5:0] tooth_number, [6] in_sync, [7] angle_regular, [8] revolution_phase,
  // [24:9] revolutions, [56:25] gap_us, [88:57] first_tooth_time, rest zero
  output logic [95:0]       m_axis_tdata,
  output logic              m_axis_tuser,   // [0] accepted
  input  logic              cfg_we_i,
  input  logic              cfg_index_i,
  input  logic [CFG_W-1:0]  cfg_wdata_i
);

  // Input register: holds one edge until the result register can take it.
  logic              in_valid_q, in_valid_d;
  logic [TIME_W-1:0] in_time_q;
  logic              out_ready, fire;
  result_t           core_res, out_res;

  assign fire          = in_valid_q && out_ready;
  assign s_axis_tready = !in_valid_q || out_ready;
  assign in_valid_d    = (s_axis_tvalid && s_axis_tready) || (in_valid_q && !out_ready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= in_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_time_q <= s_axis_tdata;
    end
  end

  // Decoder state and update logic; tooth state advances only when the edge moves on.
  cdgt_core #(
    .WRAP_TOOTH(WRAP_TOOTH)
  ) u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .fire_i      (fire),
    .tooth_time_i(in_time_q),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_idx_e'(cfg_index_i)),
    .cfg_wdata_i (cfg_wdata_i),
    .result_o    (core_res)
  );

  cdgt_outreg u_outreg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (fire),
    .result_i(core_res),
    .ready_o (out_ready),
    .valid_o (m_axis_tvalid),
    .take_i  (m_axis_tready),
    .result_o(out_res)
  );

  assign m_axis_tuser = out_res.accepted;
  assign m_axis_tdata = {7'd0,
                         out_res.first_tooth_time,
                         out_res.gap_us,
                         out_res.revolutions,
                         out_res.revolution_phase,
                         out_res.angle_regular,
                         out_res.in_sync,
                         out_res.tooth_number};

endmodule

// ===== rtl/cdgt_checker.sv =====
// Port-level assertions of the tooth decoder and their binding to the top level.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module cdgt_checker import cdgt_pkg::*; (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [95:0] m_axis_tdata,
  input logic        m_axis_tuser
);

  // A stalled result holds its payload.
  `ASSERT_RST(a_out_hold, clk_i, rst_ni,
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))

  // An edge that passed the filter always carries a nonzero tooth number.
  `ASSERT_RST(a_tooth_nonzero, clk_i, rst_ni,
    m_axis_tvalid && m_axis_tuser |-> m_axis_tdata[5:0] != '0)

  // A gap tooth is only ever tooth one or the tooth after the single gap.
  `ASSERT_RST(a_gap_tooth, clk_i, rst_ni,
    m_axis_tvalid && m_axis_tuser && !m_axis_tdata[7] |->
      m_axis_tdata[6] &&
      (m_axis_tdata[5:0] == FIRST_TOOTH || m_axis_tdata[5:0] == SINGLE_GAP_TOOTH))

  // Once in sync, the decoder stays in sync.
  `ASSERT_RST(a_sync_sticky, clk_i, rst_ni,
    m_axis_tvalid && $past(m_axis_tvalid) |-> !$fell(m_axis_tdata[6]))

  // Nothing is offered downstream while reset is held.
  `ASSERT_ALWAYS(a_reset_idle, clk_i, !rst_ni |-> !m_axis_tvalid)

endmodule

bind crank_dual_gap_tooth_decoder cdgt_checker u_cdgt_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready),
  .m_axis_tdata (m_axis_tdata),
  .m_axis_tuser (m_axis_tuser)
);
